// File: design/ucp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucp_pkg
// Shared widths and types for the unit normal cross product engine.
// ----------------------------------------------------------------------------
package ucp_pkg;

    localparam int IN_W   = 16;
    localparam int FRAC   = 14;
    localparam int OUT_W  = FRAC + 2;
    localparam int Q_W    = FRAC + 1;
    localparam int BIT_W  = $clog2(Q_W);
    localparam int N_COMP = 3;
    localparam int PROD_W = 2 * IN_W;
    localparam int C_W    = 2 * IN_W + 1;
    localparam int M_W    = 2 * IN_W;
    localparam int SQ_W   = 2 * M_W;
    localparam int S_W    = SQ_W + 2;
    localparam int CMP_W  = 2 * FRAC + 3 + S_W;

    // One component while its quotient is being built bit by bit.
    // a holds q^2 * S, b holds q * S, t holds m^2 * 2^(2F+2).
    typedef struct packed {
        logic [Q_W-1:0]   q;
        logic [CMP_W-1:0] a;
        logic [CMP_W-1:0] b;
        logic [CMP_W-1:0] t;
        logic             neg;
    } t_lane;

    typedef struct packed {
        t_lane [N_COMP-1:0] lane;
        logic [S_W-1:0]     s;
        logic               degen;
    } t_item;

endpackage

// File: design/ucp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucp_in_if / ucp_out_if
// Valid/ready channels carrying the vector pair and the unit normal.
// ----------------------------------------------------------------------------
interface ucp_in_if;
    logic                       valid;
    logic                       ready;
    logic [ucp_pkg::IN_W-1:0]   first_x;
    logic [ucp_pkg::IN_W-1:0]   first_y;
    logic [ucp_pkg::IN_W-1:0]   first_z;
    logic [ucp_pkg::IN_W-1:0]   second_x;
    logic [ucp_pkg::IN_W-1:0]   second_y;
    logic [ucp_pkg::IN_W-1:0]   second_z;

    modport source  (output valid, first_x, first_y, first_z,
                     second_x, second_y, second_z, input ready);
    modport sink    (input valid, first_x, first_y, first_z,
                     second_x, second_y, second_z, output ready);
    modport monitor (input valid, ready, first_x, first_y, first_z,
                     second_x, second_y, second_z);
endinterface

interface ucp_out_if;
    logic                       valid;
    logic                       ready;
    logic [ucp_pkg::OUT_W-1:0]  normal_x;
    logic [ucp_pkg::OUT_W-1:0]  normal_y;
    logic [ucp_pkg::OUT_W-1:0]  normal_z;
    logic                       degenerate;

    modport source  (output valid, normal_x, normal_y, normal_z, degenerate,
                     input ready);
    modport sink    (input valid, normal_x, normal_y, normal_z, degenerate,
                     output ready);
    modport monitor (input valid, ready, normal_x, normal_y, normal_z,
                     degenerate);
endinterface

// File: design/ucp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucp_front
// Cross product, component squares and squared length, four stages.
// ----------------------------------------------------------------------------
module ucp_front (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_vld,
    input  logic [ucp_pkg::N_COMP-1:0][ucp_pkg::IN_W-1:0] i_a,
    input  logic [ucp_pkg::N_COMP-1:0][ucp_pkg::IN_W-1:0] i_b,
    output logic                                        o_vld,
    output ucp_pkg::t_item                              o_item
);

    logic [3:0]                                          r_v;
    logic signed [ucp_pkg::PROD_W-1:0]                   r_p [6];
    logic signed [ucp_pkg::C_W-1:0]                      r_c [ucp_pkg::N_COMP];
    logic [ucp_pkg::N_COMP-1:0]                          r_neg;
    logic [ucp_pkg::SQ_W-1:0]                            r_sq [ucp_pkg::N_COMP];
    logic                                                r_degen2;
    ucp_pkg::t_item                                      r_item;
    logic [ucp_pkg::M_W-1:0]                             n_mag [ucp_pkg::N_COMP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_vld};
        end
    end

    always_comb begin
        for (int k = 0; k < ucp_pkg::N_COMP; k++) begin
            n_mag[k] = r_c[k][ucp_pkg::C_W-1] ? ucp_pkg::M_W'(-r_c[k])
                                              : ucp_pkg::M_W'(r_c[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= $signed(i_a[1]) * $signed(i_b[2]);
            r_p[1] <= $signed(i_a[2]) * $signed(i_b[1]);
            r_p[2] <= $signed(i_a[2]) * $signed(i_b[0]);
            r_p[3] <= $signed(i_a[0]) * $signed(i_b[2]);
            r_p[4] <= $signed(i_a[0]) * $signed(i_b[1]);
            r_p[5] <= $signed(i_a[1]) * $signed(i_b[0]);

            for (int k = 0; k < ucp_pkg::N_COMP; k++) begin
                r_c[k] <= ucp_pkg::C_W'(r_p[2*k]) - ucp_pkg::C_W'(r_p[2*k+1]);
            end

            r_degen2 <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
            for (int k = 0; k < ucp_pkg::N_COMP; k++) begin
                r_neg[k] <= r_c[k][ucp_pkg::C_W-1];
                r_sq[k]  <= ucp_pkg::SQ_W'(n_mag[k]) * ucp_pkg::SQ_W'(n_mag[k]);
            end

            r_item.s <= ucp_pkg::S_W'(r_sq[0]) + ucp_pkg::S_W'(r_sq[1])
                      + ucp_pkg::S_W'(r_sq[2]);
            r_item.degen <= r_degen2;
            for (int k = 0; k < ucp_pkg::N_COMP; k++) begin
                r_item.lane[k].q   <= '0;
                r_item.lane[k].a   <= '0;
                r_item.lane[k].b   <= '0;
                r_item.lane[k].t   <= ucp_pkg::CMP_W'(r_sq[k]) << (2 * ucp_pkg::FRAC + 2);
                r_item.lane[k].neg <= r_neg[k];
            end
        end
    end

    assign o_vld  = r_v[3];
    assign o_item = r_item;

endmodule

// File: design/ucp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucp_cell
// Decides one quotient bit for each of the three components.
// ----------------------------------------------------------------------------
module ucp_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [ucp_pkg::BIT_W-1:0] i_bit,
    input  ucp_pkg::t_item            i_item,
    output logic                      o_vld,
    output ucp_pkg::t_item            o_item
);

    logic                             r_vld;
    ucp_pkg::t_item                   r_item;
    ucp_pkg::t_item                   n_item;
    logic [ucp_pkg::CMP_W-1:0]        n_s;
    logic [ucp_pkg::CMP_W-1:0]        n_a [ucp_pkg::N_COMP];
    logic [ucp_pkg::CMP_W-1:0]        n_b [ucp_pkg::N_COMP];
    logic [ucp_pkg::CMP_W-1:0]        n_test [ucp_pkg::N_COMP];

    // Setting bit k of q: (q+2^k)^2 S = q^2 S + 2^(k+1) qS + 2^(2k) S.
    // The trial holds when (2q-1)^2 S = 4q^2 S - 4qS + S does not exceed t.
    always_comb begin
        n_item = i_item;
        n_s    = ucp_pkg::CMP_W'(i_item.s);
        for (int k = 0; k < ucp_pkg::N_COMP; k++) begin
            n_a[k] = i_item.lane[k].a + ((i_item.lane[k].b << i_bit) << 1)
                   + ((n_s << i_bit) << i_bit);
            n_b[k] = i_item.lane[k].b + (n_s << i_bit);
            n_test[k] = (n_a[k] << 2) - (n_b[k] << 2) + n_s;
            if (!i_item.lane[k].q[ucp_pkg::FRAC] && (n_test[k] <= i_item.lane[k].t)) begin
                n_item.lane[k].q = i_item.lane[k].q
                                 | (ucp_pkg::Q_W'(1) << i_bit);
                n_item.lane[k].a = n_a[k];
                n_item.lane[k].b = n_b[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// File: design/unit_normal_cross_product.sv
`timescale 1ns / 1ps
// Pipeline: 4 front stages, one cell per quotient bit (15) and the output
// register lie between an accepted input beat and its output beat.
// Throughput: one beat per cycle; the whole pipe advances together and only
// holds while the output register is full and the sink is not ready.
// Reset: synchronous, active low, clears the valid bits only.
// ----------------------------------------------------------------------------
// unit_normal_cross_product
// Unit normal of two Q8.8 vectors, delivered in Q1.14 with a degenerate flag.
// ----------------------------------------------------------------------------
module unit_normal_cross_product (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ucp_in_if.sink    i_in,
    ucp_out_if.source o_out
);

    // The cross product and its squared length S come from the front end.
    // A chain of identical cells then builds each quotient q a bit at a time,
    // most significant first. Each cell keeps q^2 S and q S updated with
    // shifts and adds only, so the test of the rounding condition
    // (2q-1)^2 S <= m^2 2^(2F+2) needs no multiplier in the chain.
    // The largest q that passes is the exactly rounded |c| 2^F / L.

    logic                        en;
    logic                        front_vld;
    ucp_pkg::t_item              front_item;
    logic [ucp_pkg::Q_W:0]       chain_vld;
    ucp_pkg::t_item              chain_item [ucp_pkg::Q_W+1];

    logic                        r_out_vld;
    logic [ucp_pkg::OUT_W-1:0]   r_nrm [ucp_pkg::N_COMP];
    logic                        r_degen;
    logic [ucp_pkg::OUT_W-1:0]   n_nrm [ucp_pkg::N_COMP];

    // The pipe moves whenever the output register is free or being drained.
    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    ucp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in.valid),
        .i_a     ({i_in.first_z, i_in.first_y, i_in.first_x}),
        .i_b     ({i_in.second_z, i_in.second_y, i_in.second_x}),
        .o_vld   (front_vld),
        .o_item  (front_item)
    );

    assign chain_vld[0]  = front_vld;
    assign chain_item[0] = front_item;

    for (genvar g = 0; g < ucp_pkg::Q_W; g++) begin : g_cell
        ucp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (chain_vld[g]),
            .i_bit   (ucp_pkg::BIT_W'(ucp_pkg::FRAC - g)),
            .i_item  (chain_item[g]),
            .o_vld   (chain_vld[g+1]),
            .o_item  (chain_item[g+1])
        );
    end

    // Apply the sign and force the zero vector when the cross product vanished.
    always_comb begin
        for (int k = 0; k < ucp_pkg::N_COMP; k++) begin
            if (chain_item[ucp_pkg::Q_W].degen) begin
                n_nrm[k] = '0;
            end else if (chain_item[ucp_pkg::Q_W].lane[k].neg) begin
                n_nrm[k] = -ucp_pkg::OUT_W'(chain_item[ucp_pkg::Q_W].lane[k].q);
            end else begin
                n_nrm[k] = ucp_pkg::OUT_W'(chain_item[ucp_pkg::Q_W].lane[k].q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= chain_vld[ucp_pkg::Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nrm   <= n_nrm;
            r_degen <= chain_item[ucp_pkg::Q_W].degen;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.normal_x   = r_nrm[0];
    assign o_out.normal_y   = r_nrm[1];
    assign o_out.normal_z   = r_nrm[2];
    assign o_out.degenerate = r_degen;

    // A degenerate beat carries the zero vector.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_degen) |-> (r_nrm[0] == '0 && r_nrm[1] == '0 && r_nrm[2] == '0))
        else $error("degenerate beat with non-zero normal");

    // A proper unit normal cannot have all components rounded to zero.
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_degen)
            |-> (r_nrm[0] != '0 || r_nrm[1] != '0 || r_nrm[2] != '0))
        else $error("non-degenerate beat with zero normal");

    // Input is refused only while a finished result waits for the sink.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_out_vld && !o_out.ready))
        else $error("input stalled without output back-pressure");

endmodule
